// ===== hw/rtl/framebuffer_blit_engine_macros.svh =====
// ----------------------------------------------------------------------------
// framebuffer blit engine assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_BLIT_ENGINE_MACROS_SVH
`define FRAMEBUFFER_BLIT_ENGINE_MACROS_SVH

// implication checked on every clock edge outside reset
`define FBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define FBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/fbe_pkg.sv =====
// ----------------------------------------------------------------------------
// fbe_pkg
// shared types and codes of the framebuffer blit engine
// ----------------------------------------------------------------------------
package fbe_pkg;

	// request kinds
	localparam logic [1:0] REQ_BLIT  = 2'd0;
	localparam logic [1:0] REQ_WRBUF = 2'd1;
	localparam logic [1:0] REQ_RDBUF = 2'd2;
	localparam logic [1:0] REQ_RDPIX = 2'd3;

	// blit operations
	localparam logic [2:0] OP_FILL = 3'd0;
	localparam logic [2:0] OP_V2B  = 3'd1;
	localparam logic [2:0] OP_B2V  = 3'd2;
	localparam logic [2:0] OP_V2V  = 3'd3;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_READY  = 2'd2;

	localparam int IN_BITS = 167;

	// decoded input item
	typedef struct packed {
		logic [31:0] buf_data;
		logic [15:0] buf_addr;
		logic [17:0] stride_bytes;
		logic [15:0] rect_height;
		logic [15:0] rect_width;
		logic [15:0] dst_y;
		logic [15:0] dst_x;
		logic [15:0] src_y;
		logic [15:0] src_x;
		logic [2:0]  blt_op;
		logic [1:0]  req_type;
	} req_t;

	// one memory access request from the sequencer
	typedef struct packed {
		logic        fs_rd;
		logic        fs_wr;
		logic        bb_rd;
		logic        bb_wr;
	} mem_ctl_t;

endpackage

// ===== hw/rtl/framebuffer_blit_engine.sv =====
// ----------------------------------------------------------------------------
// framebuffer_blit_engine
// 2D blit engine over a linear framebuffer and a word blit buffer
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_axis    in   tvalid/tready        request item (tdata)
// m_axis    out  tvalid/tready        status + read data (tdata)
// cfg       in   cfg_we               cfg_index, cfg_data
//
// steps: a word request passes ST_WORD then ST_OUT; a copy reads then writes each
//   pixel (ST_RD, ST_WR), a fill latches buffer word 0 and writes it to each pixel
// reset: a clearing pass over all MAX_WIDTH*MAX_HEIGHT words zeroes the frame store
//   before the first item is accepted
// stalls: a finished result waits in the output register; next item is
//   accepted once it is taken
// ----------------------------------------------------------------------------
module framebuffer_blit_engine #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int BUF_WORDS  = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// req_type, blt_op, src_x, src_y, dst_x, dst_y, rect_width, rect_height,
	// stride_bytes, buf_addr, buf_data (lowest bits first), zero padded
	input  logic [167:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, read_data (lowest bits first), zero padded
	output logic [39:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [8:0]   cfg_data
);
	import fbe_pkg::*;

	localparam int FS_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int FS_AW = $clog2(FS_WORDS);
	localparam int BB_AW = $clog2(BUF_WORDS);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_WORD = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;
	localparam logic [2:0] ST_FILL = 3'd7;

	logic [2:0]  state_q;
	req_t        req_q;
	logic [8:0]  fbw_q, fbh_q;
	logic        fbr_q;
	logic [FS_AW-1:0] clr_q;
	logic [15:0] xi_q, yi_q;
	logic        back_q;
	logic [17:0] pitch_q;
	logic        res_v_q;
	logic        res_st_q;
	logic [31:0] res_d_q;
	logic        wsel_q;

	mem_ctl_t         ctl;
	logic [FS_AW-1:0] fs_raddr, fs_waddr;
	logic [31:0]      fs_wdata, fs_rdata, bb_rdata, bb_wdata;
	logic [BB_AW-1:0] bb_raddr, bb_waddr;

	// effective dimensions
	logic [WW-1:0] ew;
	logic [HW-1:0] eh;
	assign ew = (32'(fbw_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fbw_q);
	assign eh = (32'(fbh_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(fbh_q);

	// rectangle bounds by subtraction
	function automatic logic fits(input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] w, input logic [15:0] h, input logic [WW-1:0] wd,
		input logic [HW-1:0] ht);
		logic [16:0] sw, sh;
		sw = 17'(wd) - 17'(x);
		sh = 17'(ht) - 17'(y);
		return !((17'(x) > 17'(wd)) || (17'(w) > sw) || (17'(y) > 17'(ht)) ||
			(17'(h) > sh));
	endfunction

	// checks for the pending blit
	logic ok_s, ok_d, ok_row_s, ok_row_d, cmd_ok;
	logic [17:0] pitch_c;
	assign pitch_c = (req_q.stride_bytes == 18'd0) ? 18'(req_q.rect_width)
		: {2'b00, req_q.stride_bytes[17:2]};
	assign ok_s = fits(req_q.src_x, req_q.src_y, req_q.rect_width,
		req_q.rect_height, ew, eh);
	assign ok_d = fits(req_q.dst_x, req_q.dst_y, req_q.rect_width,
		req_q.rect_height, ew, eh);
	assign ok_row_s = !((18'(req_q.src_x) > pitch_c) ||
		(18'(req_q.rect_width) > pitch_c - 18'(req_q.src_x)));
	assign ok_row_d = !((18'(req_q.dst_x) > pitch_c) ||
		(18'(req_q.rect_width) > pitch_c - 18'(req_q.dst_x)));
	always_comb begin
		case (req_q.blt_op)
			OP_FILL: cmd_ok = ok_d;
			OP_V2B:  cmd_ok = ok_s && ok_row_d;
			OP_B2V:  cmd_ok = ok_d && ok_row_s;
			OP_V2V:  cmd_ok = ok_s && ok_d;
			default: cmd_ok = 1'b0;
		endcase
	end

	// current pixel coordinates
	logic [15:0] cx, cy, sxp, syp, dxp, dyp;
	assign cx  = back_q ? (req_q.rect_width - 16'd1 - xi_q) : xi_q;
	assign cy  = back_q ? (req_q.rect_height - 16'd1 - yi_q) : yi_q;
	assign sxp = req_q.src_x + cx;
	assign syp = req_q.src_y + cy;
	assign dxp = req_q.dst_x + cx;
	assign dyp = req_q.dst_y + cy;

	// linear addresses; buffer rows keep their carry so they wrap modulo the buffer
	logic [FS_AW-1:0] fs_src, fs_dst;
	logic [BB_AW-1:0] bb_src, bb_dst;
	logic [33:0] bs_full, bd_full;
	assign fs_src = FS_AW'(32'(syp) * 32'(ew) + 32'(sxp));
	assign fs_dst = FS_AW'(32'(dyp) * 32'(ew) + 32'(dxp));
	assign bs_full = (34'(req_q.src_y) + 34'(cy)) * 34'(pitch_q) + 34'(sxp);
	assign bd_full = (34'(req_q.dst_y) + 34'(cy)) * 34'(pitch_q) + 34'(dxp);
	assign bb_src = bs_full[BB_AW-1:0];
	assign bb_dst = bd_full[BB_AW-1:0];

	logic last_px;
	assign last_px = (xi_q == req_q.rect_width - 16'd1) &&
		(yi_q == req_q.rect_height - 16'd1);

	logic out_free;
	assign out_free = !res_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;

	// memory request decode
	always_comb begin
		ctl = '0;
		fs_raddr = fs_src;
		fs_waddr = fs_dst;
		fs_wdata = (req_q.blt_op == OP_B2V) ? bb_rdata : fs_rdata;
		bb_raddr = bb_src;
		bb_waddr = bb_dst;
		bb_wdata = fs_rdata;
		case (state_q)
			ST_CLR: begin
				ctl.fs_wr = 1'b1;
				fs_waddr = clr_q;
				fs_wdata = 32'd0;
			end
			ST_CHK: begin
				ctl.bb_rd = 1'b1;
				bb_raddr = '0;
			end
			ST_RD: begin
				ctl.fs_rd = (req_q.blt_op == OP_V2B) || (req_q.blt_op == OP_V2V);
				ctl.bb_rd = (req_q.blt_op == OP_B2V);
			end
			ST_WR: begin
				ctl.fs_wr = (req_q.blt_op != OP_V2B) && !wsel_q;
				ctl.bb_wr = (req_q.blt_op == OP_V2B);
			end
			ST_FILL: begin
				ctl.fs_wr = 1'b1;
				fs_wdata = res_d_q;
			end
			ST_WORD: begin
				ctl.bb_wr = (req_q.req_type == REQ_WRBUF);
				ctl.bb_rd = (req_q.req_type == REQ_RDBUF);
				ctl.fs_rd = (req_q.req_type == REQ_RDPIX);
				bb_waddr = BB_AW'(req_q.buf_addr);
				bb_raddr = BB_AW'(req_q.buf_addr);
				bb_wdata = req_q.buf_data;
				fs_raddr = FS_AW'(32'(req_q.src_y) * 32'(ew) + 32'(req_q.src_x));
			end
			default: begin
			end
		endcase
	end

	fbe_mem #(.FS_AW(FS_AW), .BB_AW(BB_AW)) u_mem (
		.clk, .ctl, .fs_raddr, .fs_waddr, .fs_wdata, .bb_raddr, .bb_waddr,
		.bb_wdata, .fs_rdata, .bb_rdata
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbw_q <= 9'd256;
			fbh_q <= 9'd256;
			fbr_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  fbw_q <= cfg_data;
				REG_HEIGHT: fbh_q <= cfg_data;
				REG_READY:  fbr_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			res_v_q <= 1'b0;
			wsel_q  <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) res_v_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + FS_AW'(1);
					if (clr_q == FS_AW'(FS_WORDS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						req_q <= req_t'(s_axis_tdata[IN_BITS-1:0]);
						state_q <= (s_axis_tdata[1:0] == REQ_BLIT) ? ST_CHK : ST_WORD;
					end
				end
				ST_CHK: begin
					xi_q <= '0;
					yi_q <= '0;
					pitch_q <= pitch_c;
					res_d_q <= 32'd0;
					back_q <= (req_q.blt_op == OP_V2V) && ((req_q.dst_y > req_q.src_y) ||
						((req_q.dst_y == req_q.src_y) && (req_q.dst_x > req_q.src_x)));
					if (req_q.rect_width == 16'd0 || req_q.rect_height == 16'd0) begin
						res_st_q <= 1'b0;
						state_q <= ST_OUT;
					end else if (!fbr_q || req_q.stride_bytes[1:0] != 2'b00 || !cmd_ok)
							begin
						res_st_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						res_st_q <= 1'b0;
						wsel_q <= (req_q.blt_op == OP_FILL);
						state_q <= (req_q.blt_op == OP_FILL) ? ST_WR : ST_RD;
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					// fill latches buffer word 0 then streams writes
					if (wsel_q) begin
						res_d_q <= bb_rdata;
						wsel_q <= 1'b0;
						state_q <= ST_FILL;
					end else begin
						if (xi_q == req_q.rect_width - 16'd1) begin
							xi_q <= '0;
							yi_q <= yi_q + 16'd1;
						end else xi_q <= xi_q + 16'd1;
						state_q <= last_px ? ST_OUT : ST_RD;
					end
				end
				ST_FILL: begin
					if (xi_q == req_q.rect_width - 16'd1) begin
						xi_q <= '0;
						yi_q <= yi_q + 16'd1;
					end else xi_q <= xi_q + 16'd1;
					if (last_px) begin
						res_d_q <= 32'd0;
						state_q <= ST_OUT;
					end
				end
				ST_WORD: begin
					res_d_q <= 32'd0;
					res_st_q <= (req_q.req_type == REQ_RDPIX) &&
						!((17'(req_q.src_x) < 17'(ew)) && (17'(req_q.src_y) < 17'(eh)));
					wsel_q <= (req_q.req_type == REQ_RDPIX) &&
						(17'(req_q.src_x) < 17'(ew)) && (17'(req_q.src_y) < 17'(eh));
					back_q <= (req_q.req_type == REQ_RDBUF);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (req_q.req_type != REQ_BLIT) begin
						if (wsel_q) res_d_q <= fs_rdata;
						else if (back_q) res_d_q <= bb_rdata;
					end
					wsel_q <= 1'b0;
					back_q <= 1'b0;
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = res_v_q;
	assign m_axis_tdata = {7'd0, res_d_q, res_st_q};
endmodule

// ===== hw/rtl/fbe_mem.sv =====
// ----------------------------------------------------------------------------
// fbe_mem
// frame store and blit buffer, registered synchronous read
// ----------------------------------------------------------------------------
module fbe_mem #(
	parameter int FS_AW = 16,
	parameter int BB_AW = 16
) (
	input  logic              clk,
	input  fbe_pkg::mem_ctl_t ctl,
	input  logic [FS_AW-1:0]  fs_raddr,
	input  logic [FS_AW-1:0]  fs_waddr,
	input  logic [31:0]       fs_wdata,
	input  logic [BB_AW-1:0]  bb_raddr,
	input  logic [BB_AW-1:0]  bb_waddr,
	input  logic [31:0]       bb_wdata,
	output logic [31:0]       fs_rdata,
	output logic [31:0]       bb_rdata
);
	import fbe_pkg::*;

	logic [31:0] fs_mem [0:(1<<FS_AW)-1];
	logic [31:0] bb_mem [0:(1<<BB_AW)-1];

	// frame store port
	always_ff @(posedge clk) begin
		if (ctl.fs_wr) fs_mem[fs_waddr] <= fs_wdata;
		if (ctl.fs_rd) fs_rdata <= fs_mem[fs_raddr];
	end

	// blit buffer port
	always_ff @(posedge clk) begin
		if (ctl.bb_wr) bb_mem[bb_waddr] <= bb_wdata;
		if (ctl.bb_rd) bb_rdata <= bb_mem[bb_raddr];
	end
endmodule

// ===== hw/rtl/fbe_checker.sv =====
// ----------------------------------------------------------------------------
// fbe_checker
// port-level checks of the framebuffer blit engine
// ----------------------------------------------------------------------------
`include "framebuffer_blit_engine_macros.svh"

module fbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	// result stays until taken
	`FBE_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// no intake while a result is stuck
	`FBE_ASSERT_IMPL(a_no_take, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	// one item at a time: no intake right after one
	`FBE_ASSERT_NEXT(a_seq, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// padding bits of the result are zero
	`FBE_ASSERT_IMPL(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)
endmodule

bind framebuffer_blit_engine fbe_checker u_fbe_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

// ===== verif/tb_framebuffer_blit_engine.sv =====
// ----------------------------------------------------------------------------
// tb_framebuffer_blit_engine
// self-checking bench: a shadow framebuffer and blit buffer predict the
// status and read data of every request item; bursty sender, stalling receiver
// ----------------------------------------------------------------------------
module tb_framebuffer_blit_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import fbe_pkg::*;

	typedef struct {
		bit        status;
		bit [31:0] data;
	} resp_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [8:0]   cfg_data;

	// shadow state of the block
	bit [31:0] shadow_fs [0:65535];
	bit [31:0] shadow_bb [0:65535];
	bit [8:0]  shadow_w;
	bit [8:0]  shadow_h;
	bit        shadow_ready;

	resp_t expected_resp_q [$];
	int    mismatches;
	int    burst_left;
	int    stall_ask;
	int    stall_cnt;
	int    seg_left;
	int    ready_pct;

	framebuffer_blit_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50ms;
		$display("framebuffer_blit_engine regression: fail");
		$finish;
	end

	function automatic int unsigned eff_w();
		return (shadow_w > 256) ? 256 : shadow_w;
	endfunction

	function automatic int unsigned eff_h();
		return (shadow_h > 256) ? 256 : shadow_h;
	endfunction

	function automatic bit rect_ok(int unsigned x, int unsigned y, int unsigned w,
			int unsigned h);
		return !(x > eff_w() || w > eff_w() - x || y > eff_h() || h > eff_h() - y);
	endfunction

	function automatic bit row_ok(longint unsigned pitch, longint unsigned bx,
			longint unsigned w);
		return !(bx > pitch || w > pitch - bx);
	endfunction

	function automatic bit [15:0] fs_idx(int unsigned x, int unsigned y);
		return 16'((y * eff_w() + x) % 65536);
	endfunction

	function automatic bit [15:0] bb_idx(longint unsigned row, longint unsigned pitch,
			longint unsigned col);
		return 16'((row * pitch + col) % 65536);
	endfunction

	// blit command against the shadow state, returns status
	function automatic bit blit_status(req_t r);
		int unsigned     sx, sy, dx, dy, w, h;
		longint unsigned pitch;
		int              x, y;
		bit [31:0]       px;
		sx = r.src_x; sy = r.src_y; dx = r.dst_x; dy = r.dst_y;
		w = r.rect_width; h = r.rect_height;
		if (w == 0 || h == 0) return 1'b0;
		if (!shadow_ready) return 1'b1;
		if (r.stride_bytes[1:0] != 2'b00) return 1'b1;
		pitch = (r.stride_bytes != 0) ? longint'(r.stride_bytes >> 2) : longint'(w);
		case (r.blt_op)
			OP_FILL: begin
				if (!rect_ok(dx, dy, w, h)) return 1'b1;
				px = shadow_bb[0];
				for (y = 0; y < h; y++)
					for (x = 0; x < w; x++)
						shadow_fs[fs_idx(dx + x, dy + y)] = px;
			end
			OP_V2B: begin
				if (!rect_ok(sx, sy, w, h)) return 1'b1;
				if (!row_ok(pitch, dx, w)) return 1'b1;
				for (y = 0; y < h; y++)
					for (x = 0; x < w; x++)
						shadow_bb[bb_idx(dy + y, pitch, dx + x)] = shadow_fs[fs_idx(sx + x, sy + y)];
			end
			OP_B2V: begin
				if (!rect_ok(dx, dy, w, h)) return 1'b1;
				if (!row_ok(pitch, sx, w)) return 1'b1;
				for (y = 0; y < h; y++)
					for (x = 0; x < w; x++)
						shadow_fs[fs_idx(dx + x, dy + y)] = shadow_bb[bb_idx(sy + y, pitch, sx + x)];
			end
			OP_V2V: begin
				if (!rect_ok(sx, sy, w, h) || !rect_ok(dx, dy, w, h)) return 1'b1;
				// copy backward when the destination comes later in memory order
				if (dy > sy || (dy == sy && dx > sx)) begin
					for (y = h - 1; y >= 0; y--)
						for (x = w - 1; x >= 0; x--)
							shadow_fs[fs_idx(dx + x, dy + y)] = shadow_fs[fs_idx(sx + x, sy + y)];
				end else begin
					for (y = 0; y < h; y++)
						for (x = 0; x < w; x++)
							shadow_fs[fs_idx(dx + x, dy + y)] = shadow_fs[fs_idx(sx + x, sy + y)];
				end
			end
			default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	// expected response of one request item
	function automatic resp_t predict_resp(req_t r);
		resp_t e;
		e.status = 1'b0;
		e.data = '0;
		case (r.req_type)
			REQ_BLIT:  e.status = blit_status(r);
			REQ_WRBUF: shadow_bb[r.buf_addr] = r.buf_data;
			REQ_RDBUF: e.data = shadow_bb[r.buf_addr];
			default: begin
				if (r.src_x < eff_w() && r.src_y < eff_h())
					e.data = shadow_fs[fs_idx(r.src_x, r.src_y)];
				else
					e.status = 1'b1;
			end
		endcase
		return e;
	endfunction

	// send one item; valid stays high unless a gap follows
	task automatic send_item(req_t r);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, r};
		do @(posedge clk); while (!s_axis_tready);
		expected_resp_q.push_back(predict_resp(r));
		burst_left--;
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
	endtask

	// stop sending and let every result arrive
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_resp_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, bit [8:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH:  shadow_w = val;
			REG_HEIGHT: shadow_h = val;
			default:    shadow_ready = val[0];
		endcase
	endtask

	function automatic req_t blit_req(logic [2:0] op, int sx, int sy, int dx, int dy,
			int w, int h, int stride);
		req_t r;
		r = '0;
		r.req_type = REQ_BLIT;
		r.blt_op = op;
		r.src_x = 16'(sx); r.src_y = 16'(sy); r.dst_x = 16'(dx); r.dst_y = 16'(dy);
		r.rect_width = 16'(w); r.rect_height = 16'(h);
		r.stride_bytes = 18'(stride);
		return r;
	endfunction

	function automatic req_t word_req(logic [1:0] kind, int addr, bit [31:0] data);
		req_t r;
		r = '0;
		r.req_type = kind;
		r.buf_addr = 16'(addr);
		r.buf_data = data;
		r.src_x = 16'(addr);
		r.src_y = data[15:0];
		return r;
	endfunction

	// random item: mostly well-formed commands, some raw noise
	function automatic req_t rand_req();
		req_t        r;
		int unsigned k, w, h, ew, eh, pitch;
		r = 167'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		k = $urandom_range(0, 99);
		ew = eff_w();
		eh = eff_h();
		if (k < 15) return r;
		if (k < 30) begin
			r.req_type = REQ_WRBUF;
		end else if (k < 42) begin
			r.req_type = REQ_RDBUF;
		end else if (k < 55) begin
			r.req_type = REQ_RDPIX;
			r.src_x = 16'($urandom_range(0, ew));
			r.src_y = 16'($urandom_range(0, eh));
		end else begin
			r.req_type = REQ_BLIT;
			r.blt_op = 3'($urandom_range(0, 3));
			w = (ew == 0) ? 1 : $urandom_range(1, (ew < 16) ? ew : 16);
			h = (eh == 0) ? 1 : $urandom_range(1, (eh < 16) ? eh : 16);
			r.rect_width = 16'(w);
			r.rect_height = 16'(h);
			r.src_x = (ew >= w) ? 16'($urandom_range(0, ew - w)) : 16'd0;
			r.src_y = (eh >= h) ? 16'($urandom_range(0, eh - h)) : 16'd0;
			r.dst_x = (ew >= w) ? 16'($urandom_range(0, ew - w)) : 16'd0;
			r.dst_y = (eh >= h) ? 16'($urandom_range(0, eh - h)) : 16'd0;
			if ($urandom_range(0, 1)) begin
				r.stride_bytes = 18'd0;
				pitch = w;
			end else begin
				pitch = $urandom_range(w, 1024);
				r.stride_bytes = 18'(pitch * 4);
			end
			// buffer side: random row, column inside the pitch
			if (r.blt_op == OP_V2B) begin
				r.dst_x = 16'($urandom_range(0, pitch - w));
				r.dst_y = 16'($urandom);
			end else if (r.blt_op == OP_B2V) begin
				r.src_x = 16'($urandom_range(0, pitch - w));
				r.src_y = 16'($urandom);
			end
		end
		return r;
	endfunction

	// receiver pattern with an optional long hold-off
	always @(posedge clk) begin
		if (stall_ask > 0) begin
			stall_cnt = stall_ask;
			stall_ask = 0;
		end
		if (seg_left <= 0) begin
			seg_left = $urandom_range(1, 60);
			case ($urandom_range(0, 3))
				0: ready_pct = 100;
				1: ready_pct = 75;
				2: ready_pct = 30;
				default: ready_pct = 5;
			endcase
		end
		seg_left--;
		if (stall_cnt > 0) begin
			stall_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		resp_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_resp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d data %08h",
						m_axis_tdata[0], m_axis_tdata[32:1]);
			end else begin
				e = expected_resp_q.pop_front();
				if (m_axis_tdata[0] !== e.status || m_axis_tdata[32:1] !== e.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status %0d data %08h, got status %0d data %08h",
							e.status, e.data, m_axis_tdata[0], m_axis_tdata[32:1]);
				end
			end
		end
	end

	// requests while unarmed: a zero-size fill, a copy and pixel reads in and out of range
	task automatic test_unarmed();
		send_item(blit_req(OP_FILL, 0, 0, 0, 0, 0, 5, 0));
		send_item(blit_req(OP_V2V, 0, 0, 1, 1, 1, 1, 0));
		send_item(word_req(REQ_RDPIX, 0, 32'h0));
		send_item(word_req(REQ_RDPIX, 256, 32'h0));
		drain();
	endtask

	task automatic test_directed_ops();
		// copy the whole frame out so every buffer word holds data
		send_item(blit_req(OP_V2B, 0, 0, 0, 0, 256, 256, 1024));
		send_item(word_req(REQ_WRBUF, 0, 32'hFFFF_FFFF));
		send_item(word_req(REQ_WRBUF, 65535, 32'hA5A5_5A5A));
		send_item(word_req(REQ_RDBUF, 0, 32'h0));
		send_item(word_req(REQ_RDBUF, 65535, 32'h0));
		send_item(blit_req(OP_FILL, 0, 0, 248, 248, 8, 8, 0));
		send_item(blit_req(OP_FILL, 0, 0, 255, 0, 2, 1, 0));
		send_item(blit_req(OP_FILL, 0, 0, 0, 0, 4, 4, 6));
		send_item(blit_req(3'd5, 0, 0, 0, 0, 1, 1, 0));
		send_item(blit_req(3'd7, 0, 0, 0, 0, 1, 1, 3));
		send_item(blit_req(OP_B2V, 65530, 65535, 10, 10, 4, 4, 262140));
		send_item(blit_req(OP_V2V, 10, 10, 12, 11, 4, 4, 0));
		send_item(blit_req(OP_V2V, 12, 11, 10, 10, 4, 4, 0));
		send_item(blit_req(OP_V2V, 248, 248, 250, 248, 6, 8, 0));
		// buffer rows wrap past the end of the buffer; a row that overruns the pitch is refused
		send_item(blit_req(OP_V2B, 248, 248, 2, 65535, 4, 2, 1024));
		send_item(blit_req(OP_V2B, 0, 0, 250, 0, 8, 1, 1024));
		send_item(word_req(REQ_RDBUF, 65535 * 256 + 2, 32'h0));
		send_item(word_req(REQ_RDPIX, 255, 32'h0000_00FF));
		send_item(word_req(REQ_RDPIX, 12, 32'h0000_000B));
		drain();
	endtask

	task automatic test_random(int n, bit with_hold);
		int i;
		if (with_hold) stall_ask = 400;
		for (i = 0; i < n; i++) send_item(rand_req());
		drain();
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		shadow_w = 9'd256;
		shadow_h = 9'd256;
		shadow_ready = 1'b0;
		mismatches = 0;
		burst_left = 4;
		stall_ask = 0;
		stall_cnt = 0;
		seg_left = 0;
		ready_pct = 100;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unarmed();
		write_reg(REG_READY, 9'd1);
		test_directed_ops();
		test_random(25, 1'b1);
		write_reg(REG_WIDTH, 9'd37);
		write_reg(REG_HEIGHT, 9'd100);
		test_random(20, 1'b0);
		write_reg(REG_WIDTH, 9'd511);
		write_reg(REG_HEIGHT, 9'd300);
		test_random(20, 1'b0);
		write_reg(REG_WIDTH, 9'd1);
		write_reg(REG_HEIGHT, 9'd1);
		test_random(15, 1'b0);
		write_reg(REG_WIDTH, 9'd0);
		test_random(10, 1'b0);
		write_reg(REG_WIDTH, 9'd256);
		write_reg(REG_HEIGHT, 9'd256);
		write_reg(REG_READY, 9'd0);
		test_random(10, 1'b0);
		write_reg(REG_READY, 9'd1);
		test_random(15, 1'b0);

		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_resp_q.size() == 0)
			$display("framebuffer_blit_engine regression: pass");
		else
			$display("framebuffer_blit_engine regression: fail");
		$finish;
	end

endmodule
